### src/three_axis_moving_average_unit_assert.svh
// Assertion macros for the three-axis moving average unit.
// Included by the top level; no other dependencies.
`ifndef THREE_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TAMA_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("tama: property failed");
`define TAMA_NEVER(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("tama: forbidden condition seen");
`else
`define TAMA_ASSERT(label, clk_sig, rst_sig, prop)
`define TAMA_NEVER(label, clk_sig, rst_sig, cond)
`endif
`endif

### src/tama_pkg.sv
// Shared types and constants for the three-axis moving average unit.
// No dependencies.
`default_nettype none

package tama_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_BITS       = 11;
    localparam int AXES           = 3;
    localparam int WINDOW_MAX_DEF = 1024;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average_x;
        logic signed [SAMPLE_BITS-1:0] average_y;
        logic signed [SAMPLE_BITS-1:0] average_z;
    } average_t;

endpackage

`default_nettype wire

### src/tama_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tama_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/tama_div.sv
// Radix-2 restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one quotient bit per cycle. No dependencies.
`default_nettype none

module tama_div #(
    parameter int NUM_BITS = 26,
    parameter int DEN_BITS = 11,
    parameter int Q_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] dividend,
    input  logic        [DEN_BITS-1:0] divisor,
    output logic                       busy,
    output logic signed [Q_BITS-1:0]   quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic                neg_reg, neg_next;

    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic [Q_BITS-1:0]   mag;

    assign shifted = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        if (start)
        begin
            den_next = divisor;
            rem_next = '0;
            neg_next = dividend[NUM_BITS-1];
            quo_next = dividend[NUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            cnt_next = CNT_BITS'(NUM_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // result magnitude always fits Q_BITS; negate only the low bits
    assign mag      = quo_reg[Q_BITS-1:0];
    assign quotient = neg_reg ? $signed(-mag) : $signed(mag);
    assign busy     = (cnt_reg != '0);

endmodule

`default_nettype wire

### src/three_axis_moving_average_unit.sv
// Three-axis moving average unit: top level. Uses tama_pkg, tama_ram, tama_div
// and the assertion macros in three_axis_moving_average_unit_assert.svh.
// Samples are taken only in S_IDLE: a priming sample passes S_UPDATE; one
// that gives a result also passes S_LAUNCH and S_DIVIDE, where the bit-serial
// dividers give one quotient bit per cycle, and waits there for average_ready.
// Reset restores window_length to 1 and empties the window; the sample store
// itself is not cleared and needs no sweep.
`default_nettype none
`include "three_axis_moving_average_unit_assert.svh"

module three_axis_moving_average_unit
    import tama_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration: window_length
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data,
    // sample channel
    input  logic                sample_valid,
    output logic                sample_ready,
    input  sample_t             sample,
    // average channel
    output logic                average_valid,
    input  logic                average_ready,
    output average_t            average
);

    localparam int POS_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    // sum of up to WINDOW_MAX samples, sign included
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int RAM_WIDTH = $bits(sample_t);
    localparam logic [31:0] WMAX_WORD = 32'(WINDOW_MAX);

    // One-hot sequencer: take a beat, read-modify-write the window, then divide once the window is full.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_LAUNCH = 4'b0100,
        S_DIVIDE = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CFG_BITS-1:0]        len_reg, len_next;
    logic [CFG_BITS-1:0]        fill_reg, fill_next;
    logic [POS_BITS-1:0]        pos_reg, pos_next;
    logic signed [SUM_BITS-1:0] sum_reg  [AXES];
    logic signed [SUM_BITS-1:0] sum_next [AXES];
    sample_t                    sample_reg, sample_next;
    average_t                   average_reg, average_next;
    logic                       average_valid_reg, average_valid_next;

    logic [CFG_BITS-1:0]        len;         // active window length, clamped
    logic [POS_BITS-1:0]        pos;         // slot of this beat = oldest entry
    logic [POS_BITS-1:0]        pos_inc;
    logic                       priming;
    logic                       cfg_write;
    logic                       sample_take;
    logic                       ram_we;
    logic [RAM_WIDTH-1:0]       ram_rdata;
    logic                       div_start;
    logic [AXES-1:0]            div_busy;
    logic signed [SAMPLE_BITS-1:0] new_s [AXES];
    logic signed [SAMPLE_BITS-1:0] old_s [AXES];
    logic signed [SAMPLE_BITS-1:0] quot  [AXES];
    logic                       load_result;

    // ---------------------------------------------------------------
    // Window length: zero acts as one, anything above WINDOW_MAX clamps.
    // ---------------------------------------------------------------
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            len = CFG_BITS'(1);
        end
        else if (32'(len_reg) > WMAX_WORD)
        begin
            len = CFG_BITS'(WINDOW_MAX);
        end
        else
        begin
            len = len_reg;
        end
    end

    assign pos     = (32'(pos_reg) >= 32'(len)) ? '0 : pos_reg;
    assign pos_inc = (32'(pos) + 32'd1 >= 32'(len)) ? '0 : pos + 1'b1;
    assign priming = (fill_reg < len);

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign cfg_ready     = (state_reg == S_IDLE);
    assign cfg_write     = cfg_valid && cfg_ready;
    assign sample_ready  = (state_reg == S_IDLE);
    assign sample_take   = sample_valid && sample_ready;
    assign ram_we        = (state_reg == S_UPDATE);
    assign div_start     = (state_reg == S_LAUNCH);
    // result leaves the dividers only when the output register is free
    assign load_result   = (state_reg == S_DIVIDE) && !div_busy[0]
                           && (!average_valid_reg || average_ready);

    // ---------------------------------------------------------------
    // Window store: all three axes in one word. Read of the oldest slot is
    // issued with the input beat; the write of the same slot follows in the next
    // cycle (S_UPDATE), and the next read can only come in a later cycle, back
    // in S_IDLE, so no forwarding path is needed.
    // ---------------------------------------------------------------
    tama_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos),
        .wdata (sample_reg),
        .re    (sample_take),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    assign new_s[0] = sample_reg.sample_x;
    assign new_s[1] = sample_reg.sample_y;
    assign new_s[2] = sample_reg.sample_z;

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        assign old_s[a] = ram_rdata[(AXES-a)*SAMPLE_BITS-1 -: SAMPLE_BITS];

        // running sum: add the newest, drop the oldest once the window is full
        always_comb
        begin
            sum_next[a] = sum_reg[a];
            if (cfg_write)
            begin
                sum_next[a] = '0;
            end
            else if (state_reg == S_UPDATE)
            begin
                if (priming)
                begin
                    sum_next[a] = sum_reg[a] + SUM_BITS'(new_s[a]);
                end
                else
                begin
                    sum_next[a] = sum_reg[a] + SUM_BITS'(new_s[a])
                                  - SUM_BITS'(old_s[a]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[a] <= '0;
            end
            else
            begin
                sum_reg[a] <= sum_next[a];
            end
        end

        // one divider per axis, all three run in lockstep
        tama_div #(
            .NUM_BITS (SUM_BITS),
            .DEN_BITS (CFG_BITS),
            .Q_BITS   (SAMPLE_BITS)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (sum_reg[a]),
            .divisor  (len),
            .busy     (div_busy[a]),
            .quotient (quot[a])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer and window bookkeeping
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = priming ? S_IDLE : S_LAUNCH;
            end
            S_LAUNCH:
            begin
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (load_result)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        len_next  = len_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (cfg_write)
        begin
            // new length restarts priming
            len_next  = cfg_data;
            fill_next = '0;
            pos_next  = '0;
        end
        else if (state_reg == S_UPDATE)
        begin
            pos_next = pos_inc;
            if (priming)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    assign sample_next = sample_take ? sample : sample_reg;

    always_comb
    begin
        average_next       = average_reg;
        average_valid_next = average_valid_reg;
        if (average_valid_reg && average_ready)
        begin
            average_valid_next = 1'b0;
        end
        if (load_result)
        begin
            average_next.average_x = quot[0];
            average_next.average_y = quot[1];
            average_next.average_z = quot[2];
            average_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            len_reg           <= CFG_BITS'(1);
            fill_reg          <= '0;
            pos_reg           <= '0;
            average_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            len_reg           <= len_next;
            fill_reg          <= fill_next;
            pos_reg           <= pos_next;
            average_valid_reg <= average_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        average_reg <= average_next;
    end

    assign average_valid = average_valid_reg;
    assign average       = average_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TAMA_ASSERT(a_result_from_divide, clk, rst_n, $rose(average_valid_reg) |-> $past(state_reg == S_DIVIDE))
    `TAMA_ASSERT(a_div_lockstep, clk, rst_n, (div_busy[0] == div_busy[1]) && (div_busy[1] == div_busy[2]))
    `TAMA_ASSERT(a_priming_no_result, clk, rst_n, (state_reg == S_UPDATE && priming) |=> (state_reg == S_IDLE))
    `TAMA_NEVER(a_pos_in_window, clk, rst_n, 32'(pos_reg) >= 32'(len))

endmodule

`default_nettype wire
